FILE: rtl/q4kdq_pkg.sv
// ----------------------------------------------------------------------------
// q4kdq_pkg
// Shared types, constants and binary32 arithmetic helpers for the Q4_K core.
// ----------------------------------------------------------------------------
package q4kdq_pkg;

    localparam logic [31:0] QNAN      = 32'h7FC0_0000;
    localparam logic [3:0]  NIB_MASK  = 4'hF;
    localparam int          NIB_SHIFT = 4;
    localparam int          IN_BITS   = 88;
    localparam int          OUT_BITS  = 32;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_SCALE,
        STEP_OFFS,
        STEP_SCALED,
        STEP_W,
        STEP_PROD,
        STEP_ACC
    } step_t;

    typedef struct packed {
        logic  load;
        step_t step;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

    // position of the highest set bit, 0 when none
    function automatic logic [5:0] msb50(input logic [49:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (x[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] p;
        logic [22:0] m;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        m = 23'(man) << (5'd23 - 5'(p));
        if (ex == 5'd0) begin
            if (man == 10'd0) return {s, 31'd0};
            return {s, 8'(8'd103 + 8'(p)), m};
        end
        if (ex == 5'h1F) begin
            return {s, 8'hFF, (man != 10'd0), man[8:0], 13'd0};
        end
        return {s, 8'(8'(ex) + 8'd112), man, 13'd0};
    endfunction

    function automatic logic [31:0] int6_to_f32(input logic [5:0] v);
        logic [2:0]  p;
        logic [22:0] m;
        p = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (v[i]) p = 3'(i);
        end
        m = 23'(v) << (5'd23 - 5'(p));
        if (v == 6'd0) return 32'd0;
        return {1'b0, 8'(8'd127 + 8'(p)), m};
    endfunction

    // x holds the significand with its leading one at bit 49; value is x*2^(e-176)
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                             input logic [49:0] x);
        logic signed [11:0] ne;
        logic signed [11:0] e2;
        logic [5:0]  sh;
        logic [49:0] y;
        logic        st;
        logic        rup;
        logic [24:0] mr;
        ne = 12'sd1 - e;
        sh = 6'd0;
        if (e < 12'sd1) sh = (ne > 12'sd50) ? 6'd50 : ne[5:0];
        y   = x >> sh;
        st  = |(x & ((50'd1 << sh) - 50'd1));
        rup = y[25] & (st | (|y[24:0]) | y[26]);
        mr  = {1'b0, y[49:26]} + 25'(rup);
        if (e < 12'sd1) return {sgn, 7'd0, mr[23], mr[22:0]};
        e2 = mr[24] ? e + 12'sd1 : e;
        if (e2 >= 12'sd255) return {sgn, 8'hFF, 23'd0};
        return {sgn, e2[7:0], mr[24] ? mr[23:1] : mr[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        na, nb, ia, ib, za, zb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic [49:0] x;
        logic [5:0]  lz;
        logic signed [11:0] e;
        s  = a[31] ^ b[31];
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p  = ma * mb;
        lz = 6'd49 - msb50({p, 2'b00});
        x  = {p, 2'b00} << lz;
        e  = 12'sd0 + $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
                    + $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]})
                    - 12'sd126 - $signed({6'd0, lz});
        if (na || nb || (ia && zb) || (za && ib)) return QNAN;
        if (ia || ib) return {s, 8'hFF, 23'd0};
        if (za || zb) return {s, 31'd0};
        return fp_round(s, e, x);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi, lo;
        logic        na, nb, ia, ib;
        logic [7:0]  eh, el, d;
        logic [47:0] am, bf, bs;
        logic        stb;
        logic [48:0] r;
        logic [49:0] x;
        logic [5:0]  lz;
        logic signed [11:0] e;
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a[30:0] < b[30:0]) begin
            hi = b;
            lo = a;
        end else begin
            hi = a;
            lo = b;
        end
        eh  = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        el  = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        d   = eh - el;
        am  = {hi[30:23] != 8'd0, hi[22:0], 24'd0};
        bf  = {lo[30:23] != 8'd0, lo[22:0], 24'd0};
        bs  = (d >= 8'd48) ? 48'd0 : (bf >> d);
        stb = (d >= 8'd48) ? (|bf) : (|(bf & ((48'd1 << d) - 48'd1)));
        bs[0] = bs[0] | stb;
        r   = (hi[31] == lo[31]) ? ({1'b0, am} + {1'b0, bs}) : ({1'b0, am} - {1'b0, bs});
        lz  = 6'd49 - msb50({r, 1'b0});
        x   = {r, 1'b0} << lz;
        e   = $signed({4'd0, eh}) + 12'sd1 - $signed({6'd0, lz});
        if (na || nb || (ia && ib && (a[31] != b[31]))) return QNAN;
        if (ia) return a;
        if (ib) return b;
        if (r == 49'd0) return {a[31] & b[31], 31'd0};
        return fp_round(hi[31], e, x);
    endfunction

endpackage

FILE: rtl/q4kdq_ctrl.sv
// ----------------------------------------------------------------------------
// q4kdq_ctrl
// Sequencer: steps one accepted item through the shared multiply and add units.
// ----------------------------------------------------------------------------
module q4kdq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  q4kdq_pkg::status_t status,
    output q4kdq_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OFFS,
        ST_SCALED,
        ST_W,
        ST_PROD,
        ST_ACC
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = q4kdq_pkg::STEP_NONE;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.step   = q4kdq_pkg::STEP_SCALE;
                state_next = ST_OFFS;
            end
            ST_OFFS: begin
                cmd.step   = q4kdq_pkg::STEP_OFFS;
                state_next = ST_SCALED;
            end
            ST_SCALED: begin
                cmd.step   = q4kdq_pkg::STEP_SCALED;
                state_next = ST_W;
            end
            ST_W: begin
                cmd.step   = q4kdq_pkg::STEP_W;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.step   = q4kdq_pkg::STEP_PROD;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // hold while the previous row sum is still waiting
                if (!(status.last && status.out_busy)) begin
                    cmd.step   = q4kdq_pkg::STEP_ACC;
                    cmd.emit   = status.last;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

FILE: rtl/q4kdq_datapath.sv
// ----------------------------------------------------------------------------
// q4kdq_datapath
// Operand registers, one fp32 multiplier, one fp32 adder, accumulator, output.
// ----------------------------------------------------------------------------
module q4kdq_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  q4kdq_pkg::cmd_t                    cmd,
    output q4kdq_pkg::status_t                 status,
    input  logic [q4kdq_pkg::IN_BITS-1:0]      s_tdata,
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [q4kdq_pkg::OUT_BITS-1:0]     m_tdata
);

    logic [31:0] d_reg, dm_reg, sc_reg, mn_reg, q_reg, act_reg;
    logic [31:0] r1_reg, r2_reg, sum_reg, out_reg;
    logic        last_reg, out_valid_reg;
    logic [31:0] mul_a, mul_b, mul_y, add_a, add_b, add_y;
    logic [3:0]  nib;

    assign nib = s_tuser
        ? 4'((s_tdata[51:44] >> q4kdq_pkg::NIB_SHIFT) & 8'(q4kdq_pkg::NIB_MASK))
        : 4'(s_tdata[51:44] & 8'(q4kdq_pkg::NIB_MASK));

    always_comb begin
        mul_a = r1_reg;
        mul_b = act_reg;
        case (cmd.step)
            q4kdq_pkg::STEP_SCALE: begin
                mul_a = d_reg;
                mul_b = sc_reg;
            end
            q4kdq_pkg::STEP_OFFS: begin
                mul_a = dm_reg;
                mul_b = mn_reg;
            end
            q4kdq_pkg::STEP_SCALED: begin
                mul_a = r1_reg;
                mul_b = q_reg;
            end
            default: begin
                mul_a = r1_reg;
                mul_b = act_reg;
            end
        endcase
        if (cmd.step == q4kdq_pkg::STEP_W) begin
            add_a = r1_reg;
            add_b = {~r2_reg[31], r2_reg[30:0]};
        end else begin
            add_a = sum_reg;
            add_b = r1_reg;
        end
    end

    assign mul_y = q4kdq_pkg::fp_mul(mul_a, mul_b);
    assign add_y = q4kdq_pkg::fp_add(add_a, add_b);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg    <= q4kdq_pkg::half_to_f32(s_tdata[15:0]);
            dm_reg   <= q4kdq_pkg::half_to_f32(s_tdata[31:16]);
            sc_reg   <= q4kdq_pkg::int6_to_f32(s_tdata[37:32]);
            mn_reg   <= q4kdq_pkg::int6_to_f32(s_tdata[43:38]);
            q_reg    <= q4kdq_pkg::int6_to_f32({2'b00, nib});
            act_reg  <= s_tdata[83:52];
            last_reg <= s_tlast;
        end
        case (cmd.step)
            q4kdq_pkg::STEP_SCALE:  r1_reg <= mul_y;
            q4kdq_pkg::STEP_OFFS:   r2_reg <= mul_y;
            q4kdq_pkg::STEP_SCALED: r1_reg <= mul_y;
            q4kdq_pkg::STEP_W:      r1_reg <= add_y;
            q4kdq_pkg::STEP_PROD:   r1_reg <= mul_y;
            default: ;
        endcase
        if (cmd.step == q4kdq_pkg::STEP_ACC && cmd.emit) begin
            out_reg <= ((add_y[30:23] == 8'hFF) && (add_y[22:0] != 23'd0))
                       ? q4kdq_pkg::QNAN : add_y;
        end
        if (!aresetn) begin
            sum_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.step == q4kdq_pkg::STEP_ACC) begin
                sum_reg <= cmd.emit ? 32'd0 : add_y;
            end
            if (cmd.step == q4kdq_pkg::STEP_ACC && cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_reg;

endmodule

FILE: rtl/q4k_dequant_dot_product_core.sv
// ----------------------------------------------------------------------------
// q4k_dequant_dot_product_core
// Q4_K weight dequantize and fp32 multiply-accumulate, one 4-bit weight a beat.
// ----------------------------------------------------------------------------
// A row_last beat's row sum is registered onto m_tdata in its accumulate step.
// Six binary32 ops run one per cycle on a single shared multiplier and adder,
//   unless accumulate holds; the next input beat is taken only after the last op.
// A row-end beat holds in its accumulate step while the previous sum still waits.
// Reset (aresetn low, synchronous): accumulator to +0, output empty, idle.
// ----------------------------------------------------------------------------
module q4k_dequant_dot_product_core (
    input  logic        aclk,
    input  logic        aresetn,
    // super_scale[15:0], super_min_scale[31:16], sub_scale[37:32],
    // sub_min[43:38], quant_byte[51:44], activation[83:52], zero pad
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,   // high_half
    input  logic        s_tlast,   // row_last
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_sum[31:0]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    q4kdq_pkg::cmd_t    cmd;
    q4kdq_pkg::status_t status;

    // sequencer: order of ops is d*sc, dmin*m, scale*q, minus offset, *act, accumulate
    q4kdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, accumulator and output register (frees input side while a sum waits)
    q4kdq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/q4kdq_checker.sv
// ----------------------------------------------------------------------------
// q4kdq_checker
// Port-level checks for the Q4_K dot product core.
// ----------------------------------------------------------------------------
module q4kdq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // one beat at a time: accept closes the input side next cycle
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // emitted NaNs are canonical
    a_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0)
                       && (m_tdata != 32'h7FC0_0000)))
        else $error("non-canonical NaN");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active after reset");

endmodule

bind q4k_dequant_dot_product_core q4kdq_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
